/* src/rfid_ascii_hex_frame_parser_macros.svh */
// Assertion helpers for the RFID frame parser.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef RFID_ASCII_HEX_FRAME_PARSER_MACROS_SVH
`define RFID_ASCII_HEX_FRAME_PARSER_MACROS_SVH

// Condition that must hold in the same cycle
`define RAHFP_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger in one cycle, consequence in the next
`define RAHFP_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* src/rahfp_pkg.sv */
package rahfp_pkg;

    // Frame head byte and index of the last hex character in a frame
    localparam logic [7:0] HEAD_BYTE = 8'h02;
    localparam logic [3:0] LAST_CHAR = 4'd11;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_SUM  = 2'd1,
        STATUS_BAD_CHAR = 2'd2
    } status_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    typedef struct packed {
        logic [31:0] tag_id;
        logic [7:0]  version_byte;
        status_t     status;
    } result_t;

    // ASCII hex digit decode: 0-9, A-F, a-f
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.nib = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            // low three bits are 1..6 for A..F and a..f
            h.nib = 4'(c[2:0]) + 4'd9;
        end
        else
        begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

/* src/rfid_ascii_hex_frame_parser.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | rx_byte[7:0]
// out     | output    | out_valid / out_stall| tag_id[31:0], version_byte[7:0], frame_status[1:0]
//
// One input item per cycle while in_stall is low; a frame result is registered into the output
// entry, or into the skid entry while the output is held. Frame state updates in the same cycle
// an item is accepted, so bytes flow back to back. A two-entry output (result register plus
// skid register) keeps input open while a result waits; in_stall rises only when both entries are full.
// rst_n is asynchronous, active low, and returns the parser to hunting for a head byte.
`include "rfid_ascii_hex_frame_parser_macros.svh"

module rfid_ascii_hex_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] tag_id,
    output logic [7:0]  version_byte,
    output logic [1:0]  frame_status
);
    import rahfp_pkg::*;

    // Frame state
    logic        in_frame_reg, in_frame_next;
    logic [3:0]  char_count_reg, char_count_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [39:0] payload_shift_reg, payload_shift_next;
    logic [7:0]  running_xor_reg, running_xor_next;

    // Output and skid entries
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_data_reg, skid_data_next;

    logic        in_fire;
    logic        out_fire;
    logic        res_valid;
    result_t     res;
    hex_t        hex;
    logic [7:0]  pair;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    assign hex  = hex_decode(rx_byte);
    assign pair = {high_nibble_reg, hex.nib};

    // Per-byte frame update and result build
    always_comb
    begin
        in_frame_next      = in_frame_reg;
        char_count_next    = char_count_reg;
        high_nibble_next   = high_nibble_reg;
        payload_shift_next = payload_shift_reg;
        running_xor_next   = running_xor_reg;
        res_valid          = 1'b0;
        res.tag_id         = payload_shift_reg[31:0];
        res.version_byte   = payload_shift_reg[39:32];
        res.status         = (pair == running_xor_reg) ? STATUS_OK : STATUS_BAD_SUM;
        if (in_fire)
        begin
            if (rx_byte == HEAD_BYTE)
            begin
                // head restarts the frame wherever we are
                in_frame_next      = 1'b1;
                char_count_next    = 4'd0;
                high_nibble_next   = 4'd0;
                payload_shift_next = 40'd0;
                running_xor_next   = 8'd0;
            end
            else if (in_frame_reg)
            begin
                if (!hex.ok)
                begin
                    in_frame_next    = 1'b0;
                    char_count_next  = 4'd0;
                    res_valid        = 1'b1;
                    res.tag_id       = 32'd0;
                    res.version_byte = 8'd0;
                    res.status       = STATUS_BAD_CHAR;
                end
                else if (!char_count_reg[0])
                begin
                    high_nibble_next = hex.nib;
                    char_count_next  = char_count_reg + 4'd1;
                end
                else if (char_count_reg < LAST_CHAR)
                begin
                    payload_shift_next = {payload_shift_reg[31:0], pair};
                    running_xor_next   = running_xor_reg ^ pair;
                    char_count_next    = char_count_reg + 4'd1;
                end
                else
                begin
                    // checksum pair done
                    in_frame_next   = 1'b0;
                    char_count_next = 4'd0;
                    res_valid       = 1'b1;
                end
            end
        end
    end

    // Output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg      <= 1'b0;
            char_count_reg    <= 4'd0;
            high_nibble_reg   <= 4'd0;
            payload_shift_reg <= 40'd0;
            running_xor_reg   <= 8'd0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            in_frame_reg      <= in_frame_next;
            char_count_reg    <= char_count_next;
            high_nibble_reg   <= high_nibble_next;
            payload_shift_reg <= payload_shift_next;
            running_xor_reg   <= running_xor_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    // Result payloads, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid    = out_valid_reg;
    assign tag_id       = out_data_reg.tag_id;
    assign version_byte = out_data_reg.version_byte;
    assign frame_status = out_data_reg.status;

    // Checks
    `RAHFP_ASSERT_HOLDS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid full with empty output")
    `RAHFP_ASSERT_HOLDS(a_count_range, char_count_reg <= LAST_CHAR, "char count past last character")
    `RAHFP_ASSERT_HOLDS(a_count_in_frame, char_count_reg == 4'd0 || in_frame_reg, "count set while hunting")
    `RAHFP_ASSERT_NEXT(a_result_ends_frame, res_valid, !in_frame_reg, "frame still open after result")
    `RAHFP_ASSERT_NEXT(a_blocked_result_to_skid, res_valid && out_valid_reg && out_stall, skid_valid_reg, "blocked result lost")

endmodule

/* sim/tb.sv */
module tb;
    import rahfp_pkg::*;

    localparam int NOT_HEX       = 16;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [7:0] TAIL_BYTE = 8'h03;

    // One row of the directed table: a byte and, where obvious, its result
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    want;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] tag_id;
    logic [7:0]  version_byte;
    logic [1:0]  frame_status;

    // Frame decoder state, tracked alongside the block
    logic        parsing;
    logic [3:0]  chars_taken;
    logic [3:0]  pending_nib;
    logic [39:0] frame_bytes;
    logic [7:0]  data_xor;

    result_t     frame_results[$];
    int          busy_items;
    int          results_seen = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          send_calm;
    int          recv_calm = 0;
    step_row_t   directed_rows [0:21];

    rfid_ascii_hex_frame_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .tag_id      (tag_id),
        .version_byte(version_byte),
        .frame_status(frame_status)
    );

    always #6 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Digit value of an ASCII hex character, NOT_HEX otherwise
    function automatic int digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        return NOT_HEX;
    endfunction

    // ASCII character for a nibble, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    // Wait before the next item, drawn at random, with calm stretches of no wait
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            calm = $urandom_range(10, 60);
        return $urandom_range(0, 12);
    endfunction

    // Frame decoder: updates the tracked state for one byte
    task automatic track_byte(input logic [7:0] c, output bit emitted, output result_t res);
        int         d;
        logic [7:0] pair;
        emitted = 1'b0;
        res = '0;
        d = digit_of(c);
        pair = {pending_nib, d[3:0]};
        if (c == HEAD_BYTE)
        begin
            // head restarts the frame wherever it lands
            parsing = 1'b1;
            chars_taken = 4'd0;
            pending_nib = 4'd0;
            frame_bytes = '0;
            data_xor = 8'h00;
        end
        else if (parsing)
        begin
            if (d == NOT_HEX)
            begin
                parsing = 1'b0;
                chars_taken = 4'd0;
                emitted = 1'b1;
                res.status = STATUS_BAD_CHAR;
            end
            else if (!chars_taken[0])
            begin
                pending_nib = d[3:0];
                chars_taken++;
            end
            else if (chars_taken < LAST_CHAR)
            begin
                frame_bytes = {frame_bytes[31:0], pair};
                data_xor = data_xor ^ pair;
                chars_taken++;
            end
            else
            begin
                // checksum pair closes the frame
                emitted = 1'b1;
                res.tag_id = frame_bytes[31:0];
                res.version_byte = frame_bytes[39:32];
                res.status = (pair == data_xor) ? STATUS_OK : STATUS_BAD_SUM;
                parsing = 1'b0;
                chars_taken = 4'd0;
            end
        end
    endtask

    // Offer one byte, wait for acceptance, then record what it should produce
    task automatic offer_byte(input logic [7:0] c, input logic typed, input result_t want);
        int      gap;
        bit      emitted;
        result_t res;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= c;
        do
            @(posedge clk);
        while (in_stall);
        busy_items++;
        track_byte(c, emitted, res);
        if (emitted || typed)
            frame_results.push_back(typed ? want : res);
    endtask

    task automatic send_char(input logic [7:0] c);
        offer_byte(c, 1'b0, '0);
    endtask

    task automatic send_hex_pair(input logic [7:0] b);
        send_char(hex_char(b[7:4]));
        send_char(hex_char(b[3:0]));
    endtask

    // A byte that is neither hex nor the head, often right at a range boundary
    function automatic logic [7:0] pick_non_hex();
        logic [7:0] c;
        if ($urandom_range(0, 1))
        begin
            case ($urandom_range(0, 5))
                0: c = 8'h2F;
                1: c = 8'h3A;
                2: c = 8'h40;
                3: c = 8'h47;
                4: c = 8'h60;
                default: c = 8'h67;
            endcase
            return c;
        end
        do
            c = 8'($urandom_range(0, 255));
        while (digit_of(c) != NOT_HEX || c == HEAD_BYTE);
        return c;
    endfunction

    // One random stretch of the byte stream
    task automatic send_frame();
        int         kind;
        int         k;
        logic [7:0] b;
        logic [7:0] sum;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            // well-formed frame, mostly with a good checksum
            send_char(HEAD_BYTE);
            sum = 8'h00;
            for (int i = 0; i < 5; i++)
            begin
                case ($urandom_range(0, 7))
                    0: b = 8'h00;
                    1: b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                sum = sum ^ b;
                send_hex_pair(b);
            end
            if ($urandom_range(0, 3) == 0)
                sum = sum ^ 8'($urandom_range(1, 255));
            send_hex_pair(sum);
            if ($urandom_range(0, 3) != 0)
                send_char(TAIL_BYTE);
        end
        else if (kind < 82)
        begin
            // frame cut by a non-hex character
            send_char(HEAD_BYTE);
            k = $urandom_range(0, 11);
            repeat (k) send_char(hex_char(4'($urandom_range(0, 15))));
            send_char(pick_non_hex());
        end
        else if (kind < 92)
        begin
            // truncated frame: the next head restarts it
            send_char(HEAD_BYTE);
            k = $urandom_range(0, 11);
            repeat (k) send_char(hex_char(4'($urandom_range(0, 15))));
        end
        else
        begin
            // raw noise of any value
            k = $urandom_range(1, 4);
            repeat (k) send_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: random stalls, two long hold-offs, in-order compare
    initial
    begin
        int      n;
        result_t want;
        forever
        begin
            n = draw_wait(recv_calm);
            if (results_seen == 30 || results_seen == 90)
                n = LONG_HOLD;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && rst_n));
            results_seen++;
            if (frame_results.size() == 0)
            begin
                $error("unexpected result: tag_id %h version_byte %h frame_status %0d",
                       tag_id, version_byte, frame_status);
                mismatches++;
            end
            else
            begin
                want = frame_results.pop_front();
                if (tag_id !== want.tag_id)
                begin
                    $error("tag_id: expected %h, got %h", want.tag_id, tag_id);
                    mismatches++;
                end
                if (version_byte !== want.version_byte)
                begin
                    $error("version_byte: expected %h, got %h", want.version_byte, version_byte);
                    mismatches++;
                end
                if (frame_status !== want.status)
                begin
                    $error("frame_status: expected %0d, got %0d", want.status, frame_status);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus side
    initial
    begin
        parsing = 1'b0;
        chars_taken = 4'd0;
        pending_nib = 4'd0;
        frame_bytes = '0;
        data_xor = 8'h00;
        busy_items = 0;
        send_calm = 0;

        // ignored bytes, bad character, all-F frame with a wrong checksum, restart, bad character
        directed_rows = '{
            '{8'h00, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{HEAD_BYTE, 1'b0, '0},
            '{"G", 1'b1, '{32'h0, 8'h00, STATUS_BAD_CHAR}},
            '{HEAD_BYTE, 1'b0, '0},
            '{"f", 1'b0, '0},
            '{"F", 1'b0, '0},
            '{"F", 1'b0, '0},
            '{"f", 1'b0, '0},
            '{"F", 1'b0, '0},
            '{"f", 1'b0, '0},
            '{"F", 1'b0, '0},
            '{"f", 1'b0, '0},
            '{"F", 1'b0, '0},
            '{"f", 1'b0, '0},
            '{"F", 1'b0, '0},
            '{"e", 1'b1, '{32'hFFFF_FFFF, 8'hFF, STATUS_BAD_SUM}},
            '{HEAD_BYTE, 1'b0, '0},
            '{"9", 1'b0, '0},
            '{HEAD_BYTE, 1'b0, '0},
            '{"/", 1'b1, '{32'h0, 8'h00, STATUS_BAD_CHAR}},
            '{TAIL_BYTE, 1'b0, '0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_byte(directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);

        busy_items = 0;
        while (busy_items < RANDOM_ITEMS)
            send_frame();
        in_valid <= 1'b0;

        // drain, then let any stray result show up
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/rahfp_pkg.sv
src/rfid_ascii_hex_frame_parser.sv
sim/tb.sv
